### design/sorted_sparse_matrix_store_macros.svh
// assertion macros shared by the checker
`ifndef SORTED_SPARSE_MATRIX_STORE_MACROS_SVH
`define SORTED_SPARSE_MATRIX_STORE_MACROS_SVH

// implication in the same cycle, off during reset
`define SMS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, off during reset
`define SMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// implication into the next cycle, always on
`define SMS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/sms_pkg.sv
`timescale 1ns / 1ps
package sms_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int IDX_W        = 16;
  localparam int VAL_W        = 32;
  localparam int KEY_W        = 2 * IDX_W;
  localparam int FOUND_W      = IDX_W + 1;
  localparam int IN_W         = 72;
  localparam int OUT_W        = 72;
  localparam int CFG_IDX_W    = 1;

  localparam logic [FOUND_W-1:0] FOUND_NONE = '1;

  typedef enum logic [1:0] {
    ACT_READ   = 2'd0,
    ACT_MODIFY = 2'd1,
    ACT_FIND   = 2'd2
  } sms_action_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic [VAL_W-1:0] value;
  } sms_entry_t;

  typedef struct packed {
    logic ins;
    logic del;
    logic upd;
  } sms_ctl_t;

endpackage

### design/sms_cell.sv
`timescale 1ns / 1ps
module sms_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                     clk,
  input  logic                     cmp_en,
  input  logic [sms_pkg::KEY_W-1:0] cmp_key,
  input  logic [sms_pkg::VAL_W-1:0] cmp_val,
  input  logic [CW-1:0]            count,
  input  sms_pkg::sms_ctl_t        ctl,
  input  sms_pkg::sms_entry_t      new_entry,
  input  sms_pkg::sms_entry_t      left_entry,
  input  sms_pkg::sms_entry_t      right_entry,
  input  logic                     left_lt,
  output sms_pkg::sms_entry_t      entry,
  output logic                     lt,
  output logic                     hit,
  output logic                     match
);
  import sms_pkg::*;

  localparam logic [CW-1:0] POS = CW'(IDX);

  logic occupied;
  logic eq;
  logic at_p;

  assign occupied = POS < count;
  assign at_p     = !lt && left_lt;
  assign hit      = at_p && eq;

  // compare flags, taken when a transaction is accepted
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lt    <= occupied && ({entry.row, entry.column} < cmp_key);
      eq    <= occupied && ({entry.row, entry.column} == cmp_key);
      match <= occupied && (entry.value == cmp_val);
    end
  end

  // shift toward the tail on insert, toward the head on delete, overwrite in place on update
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (at_p) begin
        entry <= new_entry;
      end else if (!lt) begin
        entry <= left_entry;
      end
    end else if (ctl.del) begin
      if (!lt) begin
        entry <= right_entry;
      end
    end else if (ctl.upd && at_p) begin
      entry <= new_entry;
    end
  end

endmodule

### design/sorted_sparse_matrix_store.sv
`timescale 1ns / 1ps
// result: request and compare flags registered on acceptance, then the output
//   register, which waits while a stalled output transaction holds it
// transactions: one at a time, s_tready low from acceptance through the compare
//   step of the cell chain and its resolve and shift step, which waits on a stall
// reset: entry count, control state and output valid cleared, row_count and
//   column_count back to 16; entry contents stay undefined until written
module sorted_sparse_matrix_store #(
  parameter int CAPACITY = sms_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sms_pkg::IDX_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // action[1:0], row[17:2], column[33:18], value[65:34], zero fill
  input  logic [sms_pkg::IN_W-1:0]       s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // data[31:0], found_row[48:32], found_column[65:49], status[67:66], zero fill
  output logic [sms_pkg::OUT_W-1:0]      m_tdata
);
  import sms_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RES  = 2'b10
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0] row_count;
  logic [IDX_W-1:0] column_count;
  logic [CW-1:0]    count;

  logic [1:0]       req_action;
  logic [IDX_W-1:0] req_row;
  logic [IDX_W-1:0] req_column;
  logic [VAL_W-1:0] req_value;

  logic             accept;
  logic             go;
  sms_ctl_t         ctl;
  sms_entry_t       new_entry;

  sms_entry_t       entries [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] hit_vec;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] first_vec;

  logic             any_hit;
  logic             any_match;
  logic [VAL_W-1:0] hit_value;
  logic [IDX_W-1:0] first_row;
  logic [IDX_W-1:0] first_column;

  logic             is_rw;
  logic             in_range;
  logic             full;
  logic [VAL_W-1:0] res_data;
  logic [FOUND_W-1:0] res_row;
  logic [FOUND_W-1:0] res_column;
  logic [1:0]       res_status;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign go       = (state == ST_RES) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= IDX_W'(16);
      column_count <= IDX_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data;
        REG_COLUMN_COUNT: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= s_tdata[1:0];
      req_row    <= s_tdata[17:2];
      req_column <= s_tdata[33:18];
      req_value  <= s_tdata[65:34];
    end
  end

  assign new_entry = '{row: req_row, column: req_column, value: req_value};

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      sms_entry_t left_e;
      sms_entry_t right_e;
      logic       left_l;

      if (g == 0) begin : g_head
        assign left_e = new_entry;
        assign left_l = 1'b1;
      end else begin : g_body
        assign left_e = entries[g-1];
        assign left_l = lt_vec[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
        assign right_e = entries[g];
      end else begin : g_mid
        assign right_e = entries[g+1];
      end

      if (g == 0) begin : g_first0
        assign first_vec[g] = match_vec[g];
      end else begin : g_firstn
        assign first_vec[g] = match_vec[g] && !(|match_vec[g-1:0]);
      end

      sms_cell #(
        .IDX (g),
        .CW  (CW)
      ) u_cell (
        .clk         (clk),
        .cmp_en      (accept),
        .cmp_key     ({s_tdata[17:2], s_tdata[33:18]}),
        .cmp_val     (s_tdata[65:34]),
        .count       (count),
        .ctl         (ctl),
        .new_entry   (new_entry),
        .left_entry  (left_e),
        .right_entry (right_e),
        .left_lt     (left_l),
        .entry       (entries[g]),
        .lt          (lt_vec[g]),
        .hit         (hit_vec[g]),
        .match       (match_vec[g])
      );
    end
  endgenerate

  always_comb begin
    hit_value    = '0;
    first_row    = '0;
    first_column = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value    = hit_value    | (hit_vec[i]   ? entries[i].value  : '0);
      first_row    = first_row    | (first_vec[i] ? entries[i].row    : '0);
      first_column = first_column | (first_vec[i] ? entries[i].column : '0);
    end
  end

  assign any_hit   = |hit_vec;
  assign any_match = |match_vec;

  assign is_rw    = (req_action == ACT_READ) || (req_action == ACT_MODIFY);
  assign in_range = (req_row < row_count) && (req_column < column_count);
  assign full     = (count == CW'(CAPACITY));

  always_comb begin
    ctl        = '0;
    res_data   = '0;
    res_row    = FOUND_NONE;
    res_column = FOUND_NONE;
    res_status = STAT_OK;
    if (req_action == ACT_FIND) begin
      if (any_match) begin
        res_row    = {1'b0, first_row};
        res_column = {1'b0, first_column};
      end
    end else if (is_rw) begin
      if (!in_range) begin
        res_status = STAT_RANGE;
      end else begin
        if (any_hit) begin
          res_data = hit_value;
        end
        if (req_action == ACT_MODIFY) begin
          if (any_hit) begin
            ctl.upd = go && (req_value != '0);
            ctl.del = go && (req_value == '0);
          end else if (req_value != '0) begin
            if (full) begin
              res_status = STAT_FULL;
            end else begin
              ctl.ins = go;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.ins) begin
      count <= count + CW'(1);
    end else if (ctl.del) begin
      count <= count - CW'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_RES;
      ST_RES:  if (go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {(OUT_W - 68)'(0), res_status, res_column, res_row, res_data};
    end
  end

endmodule

### design/sms_checker.sv
`timescale 1ns / 1ps
`include "sorted_sparse_matrix_store_macros.svh"
module sms_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [sms_pkg::OUT_W-1:0]     m_tdata
);
  import sms_pkg::*;

  `SMS_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !m_tvalid)
  `SMS_ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  `SMS_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SMS_ASSERT_NOW(a_range_no_data, clk, rst, m_tvalid && (m_tdata[67:66] == STAT_RANGE), m_tdata[31:0] == '0)
  `SMS_ASSERT_NOW(a_find_clean, clk, rst, m_tvalid && (m_tdata[48:32] != FOUND_NONE), (m_tdata[67:66] == STAT_OK) && (m_tdata[31:0] == '0))

endmodule

bind sorted_sparse_matrix_store sms_checker u_sms_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### dv/sorted_sparse_matrix_store_tb.sv
`timescale 1ns / 1ps
module sorted_sparse_matrix_store_tb;
  import sms_pkg::*;

  localparam int STORE_DEPTH = CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic [VAL_W-1:0] value;
  } matrix_op_t;

  typedef struct packed {
    logic [VAL_W-1:0]   data;
    logic [FOUND_W-1:0] found_row;
    logic [FOUND_W-1:0] found_column;
    logic [1:0]         status;
  } matrix_res_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [IDX_W-1:0]     cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OUT_W-1:0]     m_tdata;

  sorted_sparse_matrix_store i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // shadow copy of the store and its bounds
  logic [KEY_W-1:0] shadow_key [STORE_DEPTH];
  logic [VAL_W-1:0] shadow_val [STORE_DEPTH];
  int               shadow_count;
  logic [IDX_W-1:0] row_lim;
  logic [IDX_W-1:0] col_lim;

  matrix_op_t       pending_ops [$];
  matrix_res_t      expected_res [$];
  logic [KEY_W-1:0] key_pool [$];
  logic [VAL_W-1:0] val_pool [$];

  matrix_op_t drv_op;
  logic       in_fire;
  int         src_gap;
  int         src_calm;
  int         snk_gap;
  int         snk_calm;
  int         errors;
  int         cycles;
  int         n_read, n_mod, n_find, n_spare, n_range, n_full, n_hit, peak_fill;

  function automatic matrix_res_t predict_matrix(matrix_op_t op);
    matrix_res_t      r;
    logic [KEY_W-1:0] key;
    int               p;
    int               k;
    bit               hit;
    bit               got;
    r.data         = '0;
    r.found_row    = FOUND_NONE;
    r.found_column = FOUND_NONE;
    r.status       = STAT_OK;
    key = {op.row, op.column};
    p   = 0;
    got = 0;
    if (op.action == ACT_FIND) begin
      for (k = 0; k < shadow_count && !got; k++) begin
        if (shadow_val[k] == op.value) begin
          r.found_row    = {1'b0, shadow_key[k][KEY_W-1:IDX_W]};
          r.found_column = {1'b0, shadow_key[k][IDX_W-1:0]};
          got = 1;
        end
      end
    end else if (op.action == ACT_READ || op.action == ACT_MODIFY) begin
      if (op.row >= row_lim || op.column >= col_lim) begin
        r.status = STAT_RANGE;
      end else begin
        while (p < shadow_count && shadow_key[p] < key) p++;
        hit = (p < shadow_count) && (shadow_key[p] == key);
        if (hit) r.data = shadow_val[p];
        if (op.action == ACT_MODIFY) begin
          if (hit) begin
            if (op.value == '0) begin
              for (k = p; k < shadow_count - 1; k++) begin
                shadow_key[k] = shadow_key[k+1];
                shadow_val[k] = shadow_val[k+1];
              end
              shadow_count--;
            end else begin
              shadow_val[p] = op.value;
            end
          end else if (op.value != '0) begin
            if (shadow_count >= STORE_DEPTH) begin
              r.status = STAT_FULL;
            end else begin
              for (k = shadow_count; k > p; k--) begin
                shadow_key[k] = shadow_key[k-1];
                shadow_val[k] = shadow_val[k-1];
              end
              shadow_key[p] = key;
              shadow_val[p] = op.value;
              shadow_count++;
            end
          end
        end
      end
    end
    return r;
  endfunction

  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(20, 50);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sorted_sparse_matrix_store");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (src_gap > 0) begin
        src_gap  <= src_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        drv_op = pending_ops.pop_front();
        s_tdata  <= {6'b0, drv_op.value, drv_op.column, drv_op.row, drv_op.action};
        s_tvalid <= 1'b1;
        src_gap  <= idle_len(src_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (snk_gap > 0) begin
      m_tready <= 1'b0;
      snk_gap  <= snk_gap - 1;
    end else begin
      m_tready <= 1'b1;
      snk_gap  <= idle_len(snk_calm);
    end
  end

  // monitor: predict on input transaction, compare on output transaction
  always @(posedge clk) begin
    matrix_res_t want;
    matrix_res_t got;
    in_fire <= s_tvalid && s_tready && !rst;
    if (!rst && m_tvalid && m_tready) begin
      got.data         = m_tdata[31:0];
      got.found_row    = m_tdata[48:32];
      got.found_column = m_tdata[65:49];
      got.status       = m_tdata[67:66];
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = expected_res.pop_front();
        check_field("data", want.data, got.data);
        check_field("found_row", want.found_row, got.found_row);
        check_field("found_column", want.found_column, got.found_column);
        check_field("status", want.status, got.status);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      want = predict_matrix(drv_op);
      expected_res.push_back(want);
      case (drv_op.action)
        ACT_READ:   n_read++;
        ACT_MODIFY: n_mod++;
        ACT_FIND: begin
          n_find++;
          if (want.found_row != FOUND_NONE) n_hit++;
        end
        default:    n_spare++;
      endcase
      if (want.status == STAT_RANGE) n_range++;
      if (want.status == STAT_FULL) n_full++;
      if (shadow_count > peak_fill) peak_fill = shadow_count;
    end
  end

  task automatic queue_op(input logic [1:0] action, input logic [IDX_W-1:0] row,
                          input logic [IDX_W-1:0] column, input logic [VAL_W-1:0] value);
    matrix_op_t op;
    op.action = action;
    op.row    = row;
    op.column = column;
    op.value  = value;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random(input int n, input int pct_mod, input int pct_find,
                              input int pct_zero, input int pct_fresh);
    matrix_op_t op;
    int         i;
    int         r;
    int         s;
    int         pick;
    for (i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) op.action = ACT_SPARE;
      else if (r < 3 + pct_mod) op.action = ACT_MODIFY;
      else if (r < 3 + pct_mod + pct_find) op.action = ACT_FIND;
      else op.action = ACT_READ;
      if (key_pool.size() > 0 && $urandom_range(0, 99) >= pct_fresh) begin
        pick = $urandom_range(0, key_pool.size() - 1);
        {op.row, op.column} = key_pool[pick];
      end else begin
        s = $urandom_range(0, 9);
        if (s < 7) begin
          op.row    = (row_lim == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, int'(row_lim) - 1));
          op.column = (col_lim == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, int'(col_lim) - 1));
        end else if (s == 7) begin
          op.row    = ($urandom_range(0, 1) == 0) ? row_lim : row_lim - 1;
          op.column = ($urandom_range(0, 1) == 0) ? col_lim : col_lim - 1;
        end else begin
          op.row    = IDX_W'($urandom);
          op.column = IDX_W'($urandom);
        end
      end
      if (op.action == ACT_FIND) begin
        if (val_pool.size() > 0 && $urandom_range(0, 9) < 7) begin
          op.value = val_pool[$urandom_range(0, val_pool.size() - 1)];
        end else if ($urandom_range(0, 9) == 0) begin
          op.value = '0;
        end else begin
          op.value = $urandom;
        end
      end else if ($urandom_range(0, 99) < pct_zero) begin
        op.value = '0;
      end else if (val_pool.size() > 0 && $urandom_range(0, 9) < 3) begin
        op.value = val_pool[$urandom_range(0, val_pool.size() - 1)];
      end else begin
        op.value = $urandom;
        if (op.value == '0) op.value = 32'h1;
      end
      if (op.action == ACT_MODIFY && op.value != '0) begin
        key_pool.push_back({op.row, op.column});
        val_pool.push_back(op.value);
        if (key_pool.size() > STORE_DEPTH) void'(key_pool.pop_front());
        if (val_pool.size() > STORE_DEPTH) void'(val_pool.pop_front());
      end
      pending_ops.push_back(op);
    end
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || s_tvalid || expected_res.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IDX_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx == REG_ROW_COUNT) row_lim = val;
    else col_lim = val;
  endtask

  task automatic start_phase(input logic [IDX_W-1:0] rows, input logic [IDX_W-1:0] cols);
    drain();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COLUMN_COUNT, cols);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    in_fire      = 1'b0;
    drv_op       = '0;
    src_gap      = 0;
    src_calm     = 0;
    snk_gap      = 0;
    snk_calm     = 0;
    errors       = 0;
    cycles       = 0;
    n_read       = 0;
    n_mod        = 0;
    n_find       = 0;
    n_spare      = 0;
    n_range      = 0;
    n_full       = 0;
    n_hit        = 0;
    peak_fill    = 0;
    shadow_count = 0;
    row_lim      = 16;
    col_lim      = 16;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed checks at the reset bounds
    queue_op(ACT_READ, 0, 0, 32'h0);
    queue_op(ACT_READ, 16, 0, 32'h0);
    queue_op(ACT_READ, 0, 16, 32'h0);
    queue_op(ACT_MODIFY, 16'hffff, 16'hffff, 32'h5);
    queue_op(ACT_MODIFY, 0, 0, 32'h7fffffff);
    queue_op(ACT_MODIFY, 15, 15, 32'h80000000);
    queue_op(ACT_MODIFY, 3, 5, 32'h1);
    queue_op(ACT_MODIFY, 3, 5, 32'hffffffff);
    queue_op(ACT_READ, 3, 5, 32'h0);
    queue_op(ACT_FIND, 0, 0, 32'hffffffff);
    queue_op(ACT_FIND, 0, 0, 32'h0);
    queue_op(ACT_FIND, 0, 0, 32'h00012345);
    queue_op(ACT_MODIFY, 2, 2, 32'h0);
    queue_op(ACT_MODIFY, 3, 5, 32'h0);
    queue_op(ACT_READ, 3, 5, 32'h0);
    queue_op(ACT_SPARE, 16'hffff, 16'hffff, 32'hffffffff);
    queue_op(ACT_FIND, 16'hffff, 16'hffff, 32'h80000000);
    queue_op(ACT_MODIFY, 3, 4, 32'h7fffffff);
    queue_op(ACT_FIND, 0, 0, 32'h7fffffff);
    queue_op(ACT_MODIFY, 0, 0, 32'h0);
    queue_op(ACT_FIND, 0, 0, 32'h7fffffff);
    queue_op(ACT_READ, 15, 15, 32'h0);
    queue_random(50, 50, 20, 25, 30);

    // full bounds: fill past capacity, then drain by removal
    start_phase(16'hffff, 16'hffff);
    queue_random(110, 80, 10, 5, 70);
    queue_random(50, 50, 20, 30, 20);
    queue_random(70, 85, 5, 70, 5);

    // zero bounds: only find gets through
    start_phase(16'h0000, 16'h0000);
    queue_random(30, 40, 40, 20, 50);

    start_phase(16'd300, 16'd7);
    queue_random(60, 60, 15, 50, 20);

    start_phase(16'd1, 16'hffff);
    queue_random(40, 60, 20, 30, 40);

    drain();
    $display("covered %0d transactions: %0d reads, %0d modifies, %0d finds, %0d spare actions",
             n_read + n_mod + n_find + n_spare, n_read, n_mod, n_find, n_spare);
    $display("%0d out of range, %0d dropped on a full store, %0d find hits, peak fill %0d",
             n_range, n_full, n_hit, peak_fill);
    if (errors == 0) begin
      $display("PASS sorted_sparse_matrix_store");
    end else begin
      $display("FAIL sorted_sparse_matrix_store");
    end
    $finish;
  end

endmodule
